// ----- src/tgarle_pkg.sv -----
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the run-length coded pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  localparam int BYTE_W  = 8;
  localparam int COLOR_W = 32;
  localparam int TOTAL_W = 32;
  localparam int BPP_W   = 3;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BPP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOTAL = 1'b1;

  localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd3;
  localparam logic [BPP_W-1:0]   BPP_ALPHA   = 3'd4;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd1;

  // run header h >= 128 encodes h - 127 copies, i.e. h + 129 modulo 256
  localparam logic [BYTE_W-1:0] RUN_LEN_OFS = 8'd129;
  localparam logic [BYTE_W-1:0] RAW_LEN_OFS = 8'd1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] repeat_res;
    logic              last_of_image;
    logic              status;
  } tgarle_res_t;

endpackage

// ----- src/tgarle_if.sv -----
// ----------------------------------------------------------------------------
// tgarle_if
// Valid/ready channels for coded bytes in and decoded pixels out.
// ----------------------------------------------------------------------------
interface tgarle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_image;

  modport source (output valid, output data_byte, output start_of_image, input ready);
  modport sink   (input valid, input data_byte, input start_of_image, output ready);
endinterface

interface tgarle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] repeat_res;
  logic       last_of_image;
  logic       status;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output repeat_res, output last_of_image, output status, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input repeat_res, input last_of_image, input status, output ready);
endinterface

// ----- src/tgarle_core.sv -----
// ----------------------------------------------------------------------------
// tgarle_core
// Packet decode state and the per-byte next-state / result logic.
// ----------------------------------------------------------------------------
module tgarle_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   step,
  input  logic [tgarle_pkg::BYTE_W-1:0]          data_byte,
  input  logic                                   start_of_image,
  input  logic [tgarle_pkg::BPP_W-1:0]           bytes_per_pixel,
  input  logic [tgarle_pkg::TOTAL_W-1:0]         pixel_total,
  output tgarle_pkg::tgarle_res_t                res
);
  import tgarle_pkg::*;

  logic                 expect_hdr_r, expect_hdr_nxt;
  logic                 run_pkt_r, run_pkt_nxt;
  logic [BYTE_W-1:0]    left_r, left_nxt;
  logic [1:0]           bip_r, bip_nxt;
  logic [COLOR_W-1:0]   color_r, color_nxt;
  logic [TOTAL_W-1:0]   done_r, done_nxt;
  logic                 finished_r, finished_nxt;
  logic                 failed_r, failed_nxt;

  always_comb begin
    logic [BYTE_W-1:0]  count;
    logic [BYTE_W-1:0]  rep;
    logic [BYTE_W-1:0]  addend;
    logic [TOTAL_W:0]   sum;
    logic               four;
    logic               pix_done;

    // start of image clears decode state before the byte is used
    expect_hdr_nxt = start_of_image ? 1'b1 : expect_hdr_r;
    run_pkt_nxt    = start_of_image ? 1'b0 : run_pkt_r;
    left_nxt       = start_of_image ? '0 : left_r;
    bip_nxt        = start_of_image ? '0 : bip_r;
    color_nxt      = start_of_image ? '0 : color_r;
    done_nxt       = start_of_image ? '0 : done_r;
    finished_nxt   = start_of_image ? 1'b0 : finished_r;
    failed_nxt     = start_of_image ? 1'b0 : failed_r;

    four     = (bytes_per_pixel == BPP_ALPHA);
    count    = data_byte + (data_byte[BYTE_W-1] ? RUN_LEN_OFS : RAW_LEN_OFS);
    rep      = run_pkt_nxt ? left_nxt : 8'd1;
    addend   = expect_hdr_nxt ? count : rep;
    sum      = {1'b0, done_nxt} + {{(TOTAL_W+1-BYTE_W){1'b0}}, addend};
    pix_done = four ? (bip_nxt == 2'd3) : (bip_nxt >= 2'd2);

    res = '0;

    if (!(finished_nxt || failed_nxt)) begin
      if (expect_hdr_nxt) begin
        if (sum > {1'b0, pixel_total}) begin
          failed_nxt = 1'b1;
          res.valid  = 1'b1;
          res.status = STATUS_OVERFLOW;
        end else begin
          left_nxt       = count;
          run_pkt_nxt    = data_byte[BYTE_W-1];
          bip_nxt        = '0;
          color_nxt      = '0;
          expect_hdr_nxt = 1'b0;
        end
      end else begin
        unique case (bip_nxt)
          2'd0:    color_nxt[7:0]   = data_byte;
          2'd1:    color_nxt[15:8]  = data_byte;
          2'd2:    color_nxt[23:16] = data_byte;
          default: color_nxt[31:24] = data_byte;
        endcase
        if (!pix_done) begin
          bip_nxt = bip_nxt + 2'd1;
        end else begin
          bip_nxt  = '0;
          left_nxt = run_pkt_nxt ? '0 : left_nxt - 8'd1;
          if (left_nxt == '0) begin
            expect_hdr_nxt = 1'b1;
          end
          done_nxt          = sum[TOTAL_W-1:0];
          finished_nxt      = (sum >= {1'b0, pixel_total});
          res.valid         = 1'b1;
          res.red           = color_nxt[23:16];
          res.green         = color_nxt[15:8];
          res.blue          = color_nxt[7:0];
          res.alpha         = four ? color_nxt[31:24] : '0;
          res.repeat_res    = rep;
          res.last_of_image = finished_nxt;
          res.status        = STATUS_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_hdr_r <= 1'b1;
      run_pkt_r    <= 1'b0;
      left_r       <= '0;
      bip_r        <= '0;
      color_r      <= '0;
      done_r       <= '0;
      finished_r   <= 1'b0;
      failed_r     <= 1'b0;
    end else if (step) begin
      expect_hdr_r <= expect_hdr_nxt;
      run_pkt_r    <= run_pkt_nxt;
      left_r       <= left_nxt;
      bip_r        <= bip_nxt;
      color_r      <= color_nxt;
      done_r       <= done_nxt;
      finished_r   <= finished_nxt;
      failed_r     <= failed_nxt;
    end
  end

endmodule

// ----- src/tga_rle_pixel_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// Run-length pixel decoder for true-color image data, one byte per cycle unless out_chan stalls.
// ----------------------------------------------------------------------------
// in_chan carries the coded pixel stream one byte per beat; start_of_image on
// a beat clears the decode state and takes that byte as the first packet
// header. out_chan gives one beat per finished raw pixel, one per finished
// run, and one error beat (status 1, all else 0) when a packet would pass the
// configured pixel count; after that, or after the last pixel, bytes are
// dropped until the next start_of_image.
// cfg_we / cfg_index / cfg_wdata write bytes_per_pixel (index 0) and
// pixel_total (index 1); write them only while the block is idle.
// A byte accepted into the input register is decoded from there, and its
// result is registered in the output register that drives out_chan.
// Throughput: one byte per cycle while out_chan is not stalled; the decode
// state is updated in one pass of logic from input to output register.
// When out_chan stalls the result waits in the output register; bytes that
// make no result keep flowing, and a byte that does make one waits in the
// input register, so at most two bytes are held.
// Reset clears decode state, sets bytes_per_pixel to 3 and pixel_total to 1.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  tgarle_in_if.sink                         in_chan,
  tgarle_out_if.source                      out_chan,
  input  logic                              cfg_we,
  input  logic [tgarle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgarle_pkg::TOTAL_W-1:0]    cfg_wdata
);
  import tgarle_pkg::*;

  logic [BPP_W-1:0]   bpp_r;
  logic [TOTAL_W-1:0] total_r;

  logic               in_vld_r;
  logic [BYTE_W-1:0]  in_byte_r;
  logic               in_sof_r;

  tgarle_res_t        res;
  tgarle_res_t        out_r;
  logic               out_vld_nxt;
  logic               advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r   <= BPP_RESET;
      total_r <= TOTAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_BPP:   bpp_r   <= cfg_wdata[BPP_W-1:0];
        CFG_IDX_TOTAL: total_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  tgarle_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .data_byte       (in_byte_r),
    .start_of_image  (in_sof_r),
    .bytes_per_pixel (bpp_r),
    .pixel_total     (total_r),
    .res             (res)
  );

  // a byte moves on unless its result would land on a stalled output beat
  assign advance     = in_vld_r && (!out_r.valid || out_chan.ready || !res.valid);
  assign in_chan.ready = !in_vld_r || advance;
  assign out_vld_nxt = (out_r.valid && !out_chan.ready) || (advance && res.valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.data_byte;
      in_sof_r  <= in_chan.start_of_image;
    end
  end

  // only the valid bit is reset, the payload loads with each new result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else begin
      out_r.valid <= out_vld_nxt;
    end
    if (advance && res.valid) begin
      out_r.red           <= res.red;
      out_r.green         <= res.green;
      out_r.blue          <= res.blue;
      out_r.alpha         <= res.alpha;
      out_r.repeat_res    <= res.repeat_res;
      out_r.last_of_image <= res.last_of_image;
      out_r.status        <= res.status;
    end
  end

  assign out_chan.valid         = out_r.valid;
  assign out_chan.red           = out_r.red;
  assign out_chan.green         = out_r.green;
  assign out_chan.blue          = out_r.blue;
  assign out_chan.alpha         = out_r.alpha;
  assign out_chan.repeat_res    = out_r.repeat_res;
  assign out_chan.last_of_image = out_r.last_of_image;
  assign out_chan.status        = out_r.status;

  // error beats carry no pixels, good beats always at least one
  a_err_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.valid && out_r.status |-> out_r.repeat_res == '0 && !out_r.last_of_image)
    else $error("error beat carries pixel data");

  a_ok_has_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.valid && !out_r.status |-> out_r.repeat_res != '0)
    else $error("pixel beat with zero repeat");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_byte_r) && $stable(in_sof_r))
    else $error("stalled input byte lost");

  a_no_step_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.valid && !out_chan.ready && res.valid |-> !advance)
    else $error("result overwrote a waiting output beat");

endmodule
